// File: hdl/nfa_pkg.sv
`timescale 1ns / 1ps

package nfa_pkg;

  localparam int unsigned ARENA_UNITS_DEF = 4096;
  localparam int unsigned MIN_ARENA_BYTES = 41;
  localparam int unsigned HDR_BYTES       = 16;
  localparam int unsigned FIRST_BLOCK     = 2;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned REQ_W           = 16;
  localparam int unsigned UNIT_PORT_W     = 12;
  localparam int unsigned FREE_BYTES_W    = 16;
  localparam logic [CFG_W-1:0] ARENA_RESET = 16'h8000;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ARENA = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NOT_OWNED = 3'd3,
    ST_CORRUPT   = 3'd4,
    ST_NO_FIT    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_INIT_FIRST,
    S_INIT_SENT,
    S_IDLE,
    S_A_ROVER,
    S_A_WALK,
    S_A_OWN,
    S_F_HDR,
    S_F_WALK,
    S_F_NEXT,
    S_F_PREV,
    S_DONE
  } state_e;

endpackage

// File: hdl/nfa_hdr_ram.sv
`timescale 1ns / 1ps

module nfa_hdr_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 25
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/next_fit_free_list_allocator_unit.sv
`timescale 1ns / 1ps

// Next-fit free-list allocator over one arena of 8-byte units.
// Request channel (in_valid_i/in_ready_o): req_type_i selects allocate, free or
// status query; request_bytes_i and user_unit_i carry the operands. Each
// request beat gives exactly one result beat on out_valid_o/out_ready_i:
// status, granted unit, emptiness and free bytes.
// One request at a time. Queries and out-of-range frees touch no header, and
// an unowned free reads only its own header. An allocation walks the
// free-list nodes from the rover; a free walks the nodes to bracket the
// block. The header store has one registered read port, so the walk visits
// one node per cycle.
// The result sits in an output register; while the receiver stalls a finished
// result waits there and the next one waits in the sequencer.
// Reset and every write of cfg_wdata_i (cfg_we_i) start a clearing pass over
// the whole header store, then, for a valid arena, lay down the first block
// and the sentinel. in_ready_o stays low meanwhile.
module next_fit_free_list_allocator_unit #(
  parameter int unsigned ARENA_UNITS = nfa_pkg::ARENA_UNITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [nfa_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         req_type_i,
  input  logic [nfa_pkg::REQ_W-1:0]          request_bytes_i,
  input  logic [nfa_pkg::UNIT_PORT_W-1:0]    user_unit_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2:0]                         status_o,
  output logic [nfa_pkg::UNIT_PORT_W-1:0]    alloc_unit_o,
  output logic                               arena_empty_o,
  output logic [nfa_pkg::FREE_BYTES_W-1:0]   free_bytes_o
);

  localparam int unsigned UW = $clog2(ARENA_UNITS);
  localparam int unsigned DW = 2 * UW + 1;
  localparam int unsigned BW = (UW + 4 > 16) ? UW + 4 : 16;
  localparam int unsigned CW = ((UW > 14) ? UW : 14) + 1;
  localparam logic [UW:0]   NU      = (UW+1)'(ARENA_UNITS);
  localparam logic [BW-1:0] CAP     = BW'(8 * ARENA_UNITS);
  localparam logic [BW-1:0] MIN_B   = BW'(nfa_pkg::MIN_ARENA_BYTES);
  localparam logic [BW-1:0] HDR_B   = BW'(nfa_pkg::HDR_BYTES);
  localparam logic [UW-1:0] FIRST_U = UW'(nfa_pkg::FIRST_BLOCK);
  localparam logic [UW-1:0] LAST_U  = UW'(ARENA_UNITS - 1);

  function automatic logic [UW-1:0] ix(input logic [UW:0] v);
    logic [UW:0] r;
    r = (v >= NU) ? (v - NU) : v;
    return r[UW-1:0];
  endfunction

  nfa_pkg::state_e state_q, state_d;

  logic [nfa_pkg::CFG_W-1:0] arena_q, arena_d;
  logic [UW-1:0] clr_q, clr_d;
  logic [UW-1:0] rover_q, rover_d;
  logic [UW:0]   used_q, used_d;
  logic [UW-1:0] prev_q, prev_d, p_q, p_d, h_q, h_d, nx_q, nx_d, tgt_q, tgt_d;
  logic [UW-1:0] tgt_next_q, tgt_next_d;
  logic [DW-1:0] prev_hdr_q, prev_hdr_d, p_hdr_q, p_hdr_d, h_hdr_q, h_hdr_d;
  logic [CW-1:0] need_q, need_d;
  logic [2:0]    res_status_q, res_status_d;
  logic [nfa_pkg::UNIT_PORT_W-1:0] res_unit_q, res_unit_d;

  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_status_q, out_status_d;
  logic [nfa_pkg::UNIT_PORT_W-1:0] out_unit_q, out_unit_d;
  logic          out_empty_q, out_empty_d;
  logic [nfa_pkg::FREE_BYTES_W-1:0] out_fb_q, out_fb_d;

  logic          mem_we, mem_re;
  logic [UW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  logic [BW-1:0] arena_ext, eff_bytes, eff_m16;
  logic          arena_valid;
  logic [UW-1:0] units, sent;

  always_comb begin
    arena_ext   = BW'(arena_q);
    eff_bytes   = (arena_ext > CAP) ? CAP : arena_ext;
    arena_valid = eff_bytes >= MIN_B;
    eff_m16     = eff_bytes - HDR_B;
    units       = arena_valid ? UW'(eff_m16 >> 3) : '0;
    sent        = ix({1'b0, units} + (UW+1)'(1));
  end

  nfa_hdr_ram #(
    .DEPTH (ARENA_UNITS),
    .AW    (UW),
    .DW    (DW)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nfa_pkg::S_CLEAR;
      arena_q     <= nfa_pkg::ARENA_RESET;
      clr_q       <= '0;
      rover_q     <= FIRST_U;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      arena_q     <= arena_d;
      clr_q       <= clr_d;
      rover_q     <= rover_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q       <= prev_d;
    p_q          <= p_d;
    h_q          <= h_d;
    nx_q         <= nx_d;
    tgt_q        <= tgt_d;
    tgt_next_q   <= tgt_next_d;
    prev_hdr_q   <= prev_hdr_d;
    p_hdr_q      <= p_hdr_d;
    h_hdr_q      <= h_hdr_d;
    need_q       <= need_d;
    res_status_q <= res_status_d;
    res_unit_q   <= res_unit_d;
    out_status_q <= out_status_d;
    out_unit_q   <= out_unit_d;
    out_empty_q  <= out_empty_d;
    out_fb_q     <= out_fb_d;
  end

  localparam int unsigned REQ_W_L = nfa_pkg::REQ_W + 1;
  logic          rd_own;
  logic [UW-1:0] rd_size, rd_next;
  logic [REQ_W_L-1:0] n_req;
  logic [REQ_W_L-1:0] n_round;
  logic [nfa_pkg::UNIT_PORT_W-1:0] h_in;
  logic [BW-1:0] h_bytes;
  logic [CW-1:0] size_ext;
  logic [UW-1:0] new_size, split_at;
  logic [UW:0]   sum_w, h_end, p_end;
  logic          merge;
  logic [UW-1:0] nh_size, nh_next;
  logic [UW:0]   fb_units;

  always_comb begin
    state_d      = state_q;
    arena_d      = arena_q;
    clr_d        = clr_q;
    rover_d      = rover_q;
    used_d       = used_q;
    prev_d       = prev_q;
    p_d          = p_q;
    h_d          = h_q;
    nx_d         = nx_q;
    tgt_d        = tgt_q;
    tgt_next_d   = tgt_next_q;
    prev_hdr_d   = prev_hdr_q;
    p_hdr_d      = p_hdr_q;
    h_hdr_d      = h_hdr_q;
    need_d       = need_q;
    res_status_d = res_status_q;
    res_unit_d   = res_unit_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_unit_d   = out_unit_q;
    out_empty_d  = out_empty_q;
    out_fb_d     = out_fb_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    in_ready_o   = 1'b0;

    rd_own   = mem_rdata[DW-1];
    rd_size  = mem_rdata[2*UW-1:UW];
    rd_next  = mem_rdata[UW-1:0];
    size_ext = CW'(rd_size);
    n_req    = (request_bytes_i < nfa_pkg::REQ_W'(8)) ? REQ_W_L'(8)
                                                      : REQ_W_L'(request_bytes_i);
    n_round  = n_req + REQ_W_L'(7);
    h_in     = user_unit_i - nfa_pkg::UNIT_PORT_W'(1);
    h_bytes  = BW'({h_in, 3'b000});
    new_size = UW'(size_ext - need_q);
    split_at = ix({1'b0, p_q} + {1'b0, new_size});
    sum_w    = {1'b0, p_q} + {1'b0, rd_size};
    h_end    = {1'b0, h_q} + {1'b0, h_hdr_q[2*UW-1:UW]};
    p_end    = {1'b0, p_q} + {1'b0, p_hdr_q[2*UW-1:UW]};
    merge    = (rd_size != '0) && (h_end == {1'b0, nx_q});
    nh_size  = merge ? UW'(h_hdr_q[2*UW-1:UW] + rd_size) : h_hdr_q[2*UW-1:UW];
    nh_next  = merge ? rd_next : nx_q;
    fb_units = {1'b0, units} - used_q - (UW+1)'(1);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      nfa_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + UW'(1);
        if (clr_q == LAST_U) begin
          clr_d   = '0;
          used_d  = '0;
          rover_d = FIRST_U;
          state_d = arena_valid ? nfa_pkg::S_INIT_FIRST : nfa_pkg::S_IDLE;
        end
      end
      nfa_pkg::S_INIT_FIRST: begin
        mem_we    = 1'b1;
        mem_waddr = FIRST_U;
        mem_wdata = {1'b0, UW'(units - UW'(1)), sent};
        state_d   = nfa_pkg::S_INIT_SENT;
      end
      nfa_pkg::S_INIT_SENT: begin
        mem_we    = 1'b1;
        mem_waddr = sent;
        mem_wdata = {1'b0, UW'(0), FIRST_U};
        state_d   = nfa_pkg::S_IDLE;
      end
      nfa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_unit_d   = '0;
          res_status_d = nfa_pkg::ST_OK;
          state_d      = nfa_pkg::S_DONE;
          need_d       = CW'(n_round >> 3) + CW'(1);
          h_d          = UW'(h_in);
          if (!arena_valid) begin
            res_status_d = nfa_pkg::ST_BAD_ARENA;
          end else begin
            case (req_type_i)
              nfa_pkg::REQ_ALLOC: begin
                mem_re    = 1'b1;
                mem_raddr = rover_q;
                state_d   = nfa_pkg::S_A_ROVER;
              end
              nfa_pkg::REQ_FREE: begin
                if (user_unit_i == '0 || h_in < nfa_pkg::UNIT_PORT_W'(2) ||
                    h_bytes >= eff_bytes) begin
                  res_status_d = nfa_pkg::ST_RANGE;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = UW'(h_in);
                  state_d   = nfa_pkg::S_F_HDR;
                end
              end
              default: begin
                res_status_d = nfa_pkg::ST_OK;
              end
            endcase
          end
        end
      end
      nfa_pkg::S_A_ROVER: begin
        prev_d     = rover_q;
        prev_hdr_d = mem_rdata;
        p_d        = rd_next;
        mem_re     = 1'b1;
        mem_raddr  = rd_next;
        state_d    = nfa_pkg::S_A_WALK;
      end
      nfa_pkg::S_A_WALK: begin
        if (size_ext >= need_q) begin
          mem_we = 1'b1;
          if (size_ext == need_q) begin
            mem_waddr  = prev_q;
            mem_wdata  = {prev_hdr_q[DW-1:UW], rd_next};
            tgt_d      = p_q;
            tgt_next_d = rd_next;
          end else begin
            mem_waddr  = p_q;
            mem_wdata  = {rd_own, new_size, rd_next};
            tgt_d      = split_at;
            tgt_next_d = '0;
          end
          rover_d = prev_q;
          used_d  = used_q + (UW+1)'(need_q);
          state_d = nfa_pkg::S_A_OWN;
        end else if (p_q == rover_q) begin
          res_status_d = nfa_pkg::ST_NO_FIT;
          state_d      = nfa_pkg::S_DONE;
        end else begin
          prev_d     = p_q;
          prev_hdr_d = mem_rdata;
          p_d        = rd_next;
          mem_re     = 1'b1;
          mem_raddr  = rd_next;
        end
      end
      nfa_pkg::S_A_OWN: begin
        mem_we       = 1'b1;
        mem_waddr    = tgt_q;
        mem_wdata    = {1'b1, UW'(need_q), tgt_next_q};
        res_status_d = nfa_pkg::ST_OK;
        res_unit_d   = nfa_pkg::UNIT_PORT_W'({1'b0, tgt_q} + (UW+1)'(1));
        state_d      = nfa_pkg::S_DONE;
      end
      nfa_pkg::S_F_HDR: begin
        h_hdr_d = mem_rdata;
        if (!rd_own) begin
          res_status_d = nfa_pkg::ST_NOT_OWNED;
          state_d      = nfa_pkg::S_DONE;
        end else begin
          p_d       = rover_q;
          mem_re    = 1'b1;
          mem_raddr = rover_q;
          state_d   = nfa_pkg::S_F_WALK;
        end
      end
      nfa_pkg::S_F_WALK: begin
        if (h_q == p_q || h_q == rd_next ||
            (p_q < h_q && sum_w > {1'b0, h_q})) begin
          res_status_d = nfa_pkg::ST_CORRUPT;
          state_d      = nfa_pkg::S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_next;
          if ((p_q < rd_next) ? (p_q < h_q && h_q < rd_next)
                              : (h_q > p_q || h_q < rd_next)) begin
            p_hdr_d = mem_rdata;
            nx_d    = rd_next;
            state_d = nfa_pkg::S_F_NEXT;
          end else begin
            p_d = rd_next;
          end
        end
      end
      nfa_pkg::S_F_NEXT: begin
        if (rd_size != '0 && h_end > {1'b0, nx_q}) begin
          res_status_d = nfa_pkg::ST_CORRUPT;
          state_d      = nfa_pkg::S_DONE;
        end else begin
          used_d    = used_q - {1'b0, h_hdr_q[2*UW-1:UW]};
          mem_we    = 1'b1;
          mem_waddr = h_q;
          mem_wdata = {1'b0, nh_size, nh_next};
          h_hdr_d   = {1'b0, nh_size, nh_next};
          state_d   = nfa_pkg::S_F_PREV;
        end
      end
      nfa_pkg::S_F_PREV: begin
        mem_we    = 1'b1;
        mem_waddr = p_q;
        if (p_end == {1'b0, h_q}) begin
          mem_wdata = {p_hdr_q[DW-1],
                       UW'(p_hdr_q[2*UW-1:UW] + h_hdr_q[2*UW-1:UW]),
                       h_hdr_q[UW-1:0]};
        end else begin
          mem_wdata = {p_hdr_q[DW-1:UW], h_q};
        end
        rover_d      = p_q;
        res_status_d = nfa_pkg::ST_OK;
        state_d      = nfa_pkg::S_DONE;
      end
      nfa_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_unit_d   = (res_status_q == nfa_pkg::ST_OK) ? res_unit_q : '0;
          out_empty_d  = arena_valid && (used_q == '0);
          out_fb_d     = arena_valid ? nfa_pkg::FREE_BYTES_W'({fb_units, 3'b000}) : '0;
          state_d      = nfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = nfa_pkg::S_CLEAR;
      end
    endcase

    if (cfg_we_i) begin
      arena_d = cfg_wdata_i;
      clr_d   = '0;
      state_d = nfa_pkg::S_CLEAR;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign alloc_unit_o  = out_unit_q;
  assign arena_empty_o = out_empty_q;
  assign free_bytes_o  = out_fb_q;

endmodule
